/* design/mspid_pkg.sv */
// ============================================================================
// mspid_pkg: shared constants and types for the motor speed/position PID
// Widths of the item fields, register indexes, loop mode codes and the
// sizing of the shared multiplier, accumulator and divider.
// ============================================================================
package mspid_pkg;

  // Control constants
  localparam int ERROR_LIMIT    = 100000;
  localparam int GAIN_FRAC_BITS = 8;
  localparam int SPEED_SCALE    = 6000;

  // Field widths
  localparam int DELTA_W    = 21;
  localparam int WORD_W     = 32;
  localparam int DUTY_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int PPR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Datapath widths
  localparam int MUL_B_W = WORD_W + 1;            // 33-bit signed operand
  localparam int PROD_W  = GAIN_W + MUL_B_W;      // 49-bit product
  localparam int ACC_W   = PROD_W + 1;            // sum of three products
  localparam int SCL_W   = ACC_W - GAIN_FRAC_BITS;
  localparam int DUTY_SUM_W = SCL_W + 1;

  // Divider sizing: dividend is |delta * 6000| < 2^33
  localparam int DIV_N_W   = WORD_W + 1;
  localparam int DIV_STEPS = DIV_N_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Loop mode codes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_NONE  = 2'd0;
  localparam mode_t MODE_SPEED = 2'd1;
  localparam mode_t MODE_POS   = 2'd2;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_LOOP_MODE  = 3'd0;
  localparam cfg_idx_t REG_PPR        = 3'd1;
  localparam cfg_idx_t REG_TARGET     = 3'd2;
  localparam cfg_idx_t REG_GAIN_ONE   = 3'd3;
  localparam cfg_idx_t REG_GAIN_TWO   = 3'd4;
  localparam cfg_idx_t REG_GAIN_THREE = 3'd5;
  localparam cfg_idx_t REG_DUTY_MAX   = 3'd6;
  localparam cfg_idx_t REG_DEADBAND   = 3'd7;

endpackage

/* design/mspid_ifs.sv */
// ============================================================================
// mspid interfaces: valid/ready channels for input and result items
// One interface per channel, each with a source and a sink modport.
// ============================================================================
interface mspid_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mspid_pkg::DELTA_W-1:0]     count_delta;

  modport source (output valid, output count_delta, input ready);
  modport sink   (input valid, input count_delta, output ready);
endinterface

interface mspid_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [mspid_pkg::DUTY_W-1:0]      duty;
  logic signed [mspid_pkg::WORD_W-1:0]      speed;
  logic signed [mspid_pkg::WORD_W-1:0]      position;
  logic signed [mspid_pkg::WORD_W-1:0]      error_used;

  modport source (output valid, output duty, output speed, output position,
                  output error_used, input ready);
  modport sink   (input valid, input duty, input speed, input position,
                  input error_used, output ready);
endinterface

/* design/mspid_div.sv */
// ============================================================================
// mspid_div: restoring divider, one quotient bit per cycle
// Unsigned 33-bit dividend by 16-bit divisor; done pulses after the last step.
// ============================================================================
module mspid_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [mspid_pkg::DIV_N_W-1:0]    dividend,
  input  logic [mspid_pkg::PPR_W-1:0]      divisor,
  output logic                             done,
  output logic [mspid_pkg::DIV_N_W-1:0]    quotient
);

  logic                                busy_r;
  logic                                done_r;
  logic [mspid_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [mspid_pkg::PPR_W-1:0]         rem_r;
  logic [mspid_pkg::PPR_W-1:0]         dvs_r;
  logic [mspid_pkg::DIV_N_W-1:0]       quo_r;

  logic [mspid_pkg::PPR_W:0]           rem_sh;
  logic [mspid_pkg::PPR_W:0]           rem_diff;
  logic                                take;

  assign rem_sh   = {rem_r, quo_r[mspid_pkg::DIV_N_W-1]};
  assign take     = (rem_sh >= {1'b0, dvs_r});
  assign rem_diff = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == mspid_pkg::DIV_CNT_W'(mspid_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      // shift one dividend bit in, subtract when it fits
      rem_r <= take ? rem_diff[mspid_pkg::PPR_W-1:0] : rem_sh[mspid_pkg::PPR_W-1:0];
      quo_r <= {quo_r[mspid_pkg::DIV_N_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/motor_speed_position_pid.sv */
// ============================================================================
// motor_speed_position_pid: speed and position PID for one motor channel
// Derives speed and position from the encoder count change of each control
// period and runs an incremental (speed) or positional (position) PID.
// ============================================================================
// Flow: one item at a time; a new input is accepted only in idle, after the
//   previous result has been loaded, so a stalled result holds the sequencer.
//   Speed uses the 33-step divider; one 16x33 multiplier is shared.
// Reset (rst_n, synchronous, active low): registers go to their reset values,
//   duty, error history, error sum and position clear; no result is pending.
module motor_speed_position_pid (
  input  logic                                clk,
  input  logic                                rst_n,
  mspid_in_if.sink                            in_ch,
  mspid_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [mspid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mspid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // Sequencer states, one-hot
  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0_0000_0000_0001,
    ST_SPD_MUL  = 13'b0_0000_0000_0010,
    ST_DIV_GO   = 13'b0_0000_0000_0100,
    ST_DIV_WAIT = 13'b0_0000_0000_1000,
    ST_ERR      = 13'b0_0000_0001_0000,
    ST_LIM      = 13'b0_0000_0010_0000,
    ST_SUM      = 13'b0_0000_0100_0000,
    ST_M1       = 13'b0_0000_1000_0000,
    ST_M2       = 13'b0_0001_0000_0000,
    ST_M3       = 13'b0_0010_0000_0000,
    ST_SCL      = 13'b0_0100_0000_0000,
    ST_CLP      = 13'b0_1000_0000_0000,
    ST_OUT      = 13'b1_0000_0000_0000
  } state_t;

  localparam logic [mspid_pkg::DIV_N_W-1:0] Q_POS_MAX = 33'h0_7FFF_FFFF;
  localparam logic [mspid_pkg::DIV_N_W-1:0] Q_NEG_MAX = 33'h0_8000_0000;
  localparam logic signed [mspid_pkg::ACC_W-1:0] FRAC_MASK =
    mspid_pkg::ACC_W'((1 << mspid_pkg::GAIN_FRAC_BITS) - 1);

  // Configuration registers
  mspid_pkg::mode_t                           mode_r;
  logic        [mspid_pkg::PPR_W-1:0]         ppr_r;
  logic signed [mspid_pkg::WORD_W-1:0]        target_r;
  logic signed [mspid_pkg::GAIN_W-1:0]        g1_r;
  logic signed [mspid_pkg::GAIN_W-1:0]        g2_r;
  logic signed [mspid_pkg::GAIN_W-1:0]        g3_r;
  logic        [mspid_pkg::DUTY_W-1:0]        dmax_r;
  logic        [mspid_pkg::DUTY_W-1:0]        dband_r;

  // Controller state
  logic        [mspid_pkg::DUTY_W-1:0]        duty_r;
  logic signed [mspid_pkg::WORD_W-1:0]        last_r;
  logic signed [mspid_pkg::WORD_W-1:0]        prior_r;
  logic signed [mspid_pkg::WORD_W-1:0]        sum_r;
  logic signed [mspid_pkg::WORD_W-1:0]        pos_r;

  // Working registers
  state_t                                     state_r, state_nxt;
  logic signed [mspid_pkg::MUL_B_W-1:0]       delta_r;
  logic signed [mspid_pkg::ACC_W-1:0]         acc_r;
  logic                                       spd_neg_r;
  logic signed [mspid_pkg::WORD_W-1:0]        speed_r;
  logic signed [mspid_pkg::MUL_B_W-1:0]       ediff_r;
  logic signed [mspid_pkg::WORD_W-1:0]        err_r;
  logic signed [mspid_pkg::SCL_W-1:0]         scaled_r;

  // Result register
  logic                                       out_valid_r;
  logic        [mspid_pkg::DUTY_W-1:0]        out_duty_r;
  logic signed [mspid_pkg::WORD_W-1:0]        out_speed_r;
  logic signed [mspid_pkg::WORD_W-1:0]        out_pos_r;
  logic signed [mspid_pkg::WORD_W-1:0]        out_err_r;

  // Shared multiplier
  logic signed [mspid_pkg::GAIN_W-1:0]        mul_a;
  logic signed [mspid_pkg::MUL_B_W-1:0]       mul_b;
  logic signed [mspid_pkg::PROD_W-1:0]        prod;

  // Divider hookup
  logic                                       div_start;
  logic                                       div_done;
  logic        [mspid_pkg::DIV_N_W-1:0]       div_dividend;
  logic        [mspid_pkg::PPR_W-1:0]         div_divisor;
  logic        [mspid_pkg::DIV_N_W-1:0]       div_quo;

  // Misc combinational
  logic                                       in_fire;
  logic                                       out_free;
  logic                                       loop_on;
  logic                                       is_speed;
  logic signed [mspid_pkg::ACC_W-1:0]         acc_neg;
  logic signed [mspid_pkg::ACC_W-1:0]         acc_bias;
  logic signed [mspid_pkg::WORD_W-1:0]        meas;
  logic        [mspid_pkg::MUL_B_W-1:0]       emag;
  logic signed [mspid_pkg::MUL_B_W-1:0]       sum_wide;
  logic signed [mspid_pkg::DUTY_SUM_W-1:0]    duty_sum;
  logic signed [mspid_pkg::DUTY_SUM_W-1:0]    dmax_ext;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign loop_on  = (mode_r == mspid_pkg::MODE_SPEED) || (mode_r == mspid_pkg::MODE_POS);
  assign is_speed = (mode_r == mspid_pkg::MODE_SPEED);

  // ---------------------------------------------------------------------------
  // Configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= mspid_pkg::MODE_NONE;
      ppr_r    <= mspid_pkg::PPR_W'(1);
      target_r <= '0;
      g1_r     <= '0;
      g2_r     <= '0;
      g3_r     <= '0;
      dmax_r   <= '0;
      dband_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mspid_pkg::REG_LOOP_MODE:  mode_r   <= cfg_wdata[1:0];
        mspid_pkg::REG_PPR:        ppr_r    <= cfg_wdata[mspid_pkg::PPR_W-1:0];
        mspid_pkg::REG_TARGET:     target_r <= cfg_wdata;
        mspid_pkg::REG_GAIN_ONE:   g1_r     <= cfg_wdata[mspid_pkg::GAIN_W-1:0];
        mspid_pkg::REG_GAIN_TWO:   g2_r     <= cfg_wdata[mspid_pkg::GAIN_W-1:0];
        mspid_pkg::REG_GAIN_THREE: g3_r     <= cfg_wdata[mspid_pkg::GAIN_W-1:0];
        mspid_pkg::REG_DUTY_MAX:   dmax_r   <= cfg_wdata[mspid_pkg::DUTY_W-1:0];
        mspid_pkg::REG_DEADBAND:   dband_r  <= cfg_wdata[mspid_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operand select by state
  //   speed scaling  : delta * 6000
  //   speed loop     : g1*e, g2*(-last), g3*prior
  //   position loop  : g1*e, g2*sum,     g3*(e - last)
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = g1_r;
    mul_b = mspid_pkg::MUL_B_W'(err_r);
    case (state_r)
      ST_SPD_MUL: begin
        mul_a = mspid_pkg::GAIN_W'(mspid_pkg::SPEED_SCALE);
        mul_b = delta_r;
      end
      ST_M2: begin
        mul_a = g2_r;
        mul_b = is_speed ? -mspid_pkg::MUL_B_W'(last_r) : mspid_pkg::MUL_B_W'(sum_r);
      end
      ST_M3: begin
        mul_a = g3_r;
        mul_b = is_speed ? mspid_pkg::MUL_B_W'(prior_r)
                         : mspid_pkg::MUL_B_W'(err_r) - mspid_pkg::MUL_B_W'(last_r);
      end
      default: ;
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Speed divider: |delta*6000| / ppr, zero ppr treated as one
  // ---------------------------------------------------------------------------
  assign acc_neg      = -acc_r;
  assign div_start    = (state_r == ST_DIV_GO);
  assign div_dividend = acc_r[mspid_pkg::ACC_W-1] ? acc_neg[mspid_pkg::DIV_N_W-1:0]
                                                  : acc_r[mspid_pkg::DIV_N_W-1:0];
  assign div_divisor  = (ppr_r == '0) ? mspid_pkg::PPR_W'(1) : ppr_r;

  mspid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Error, sum, scaling and clamp helpers
  // ---------------------------------------------------------------------------
  assign meas     = is_speed ? speed_r : pos_r;
  assign emag     = ediff_r[mspid_pkg::MUL_B_W-1] ? -ediff_r : ediff_r;
  assign sum_wide = mspid_pkg::MUL_B_W'(sum_r) + mspid_pkg::MUL_B_W'(err_r);
  // bias negatives so the shift truncates toward zero
  assign acc_bias = acc_r + (acc_r[mspid_pkg::ACC_W-1] ? FRAC_MASK : '0);
  assign dmax_ext = signed'(mspid_pkg::DUTY_SUM_W'(dmax_r));
  assign duty_sum = mspid_pkg::DUTY_SUM_W'(scaled_r)
                  + (is_speed ? signed'(mspid_pkg::DUTY_SUM_W'(duty_r)) : '0);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_fire) state_nxt = ST_SPD_MUL;
      ST_SPD_MUL:  state_nxt = ST_DIV_GO;
      ST_DIV_GO:   state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_nxt = ST_ERR;
      ST_ERR:      state_nxt = loop_on ? ST_LIM : ST_OUT;
      ST_LIM:      state_nxt = ST_SUM;
      ST_SUM:      state_nxt = ST_M1;
      ST_M1:       state_nxt = ST_M2;
      ST_M2:       state_nxt = ST_M3;
      ST_M3:       state_nxt = ST_SCL;
      ST_SCL:      state_nxt = ST_CLP;
      ST_CLP:      state_nxt = ST_OUT;
      ST_OUT:      if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state: duty, error history, error sum, position
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r  <= '0;
      last_r  <= '0;
      prior_r <= '0;
      sum_r   <= '0;
      pos_r   <= '0;
    end else begin
      // accumulate position with wrap on accept
      if (in_fire) begin
        pos_r <= pos_r + mspid_pkg::WORD_W'(in_ch.count_delta);
      end
      // saturate the error sum in the position loop
      if (state_r == ST_SUM && mode_r == mspid_pkg::MODE_POS) begin
        if (sum_wide[mspid_pkg::MUL_B_W-1] != sum_wide[mspid_pkg::WORD_W-1]) begin
          sum_r <= sum_wide[mspid_pkg::MUL_B_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
          sum_r <= sum_wide[mspid_pkg::WORD_W-1:0];
        end
      end
      // clamp to 0..duty_max and shift the error history
      if (state_r == ST_CLP) begin
        if (duty_sum[mspid_pkg::DUTY_SUM_W-1]) begin
          duty_r <= '0;
        end else if (duty_sum > dmax_ext) begin
          duty_r <= dmax_r;
        end else begin
          duty_r <= duty_sum[mspid_pkg::DUTY_W-1:0];
        end
        prior_r <= last_r;
        last_r  <= err_r;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath working registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      delta_r <= mspid_pkg::MUL_B_W'(in_ch.count_delta);
    end
    case (state_r)
      ST_SPD_MUL: acc_r <= mspid_pkg::ACC_W'(prod);
      ST_DIV_GO:  spd_neg_r <= acc_r[mspid_pkg::ACC_W-1];
      ST_DIV_WAIT: begin
        // truncated quotient, saturated to 32 bits
        if (spd_neg_r) begin
          speed_r <= (div_quo > Q_NEG_MAX) ? 32'sh8000_0000
                                           : -signed'(div_quo[mspid_pkg::WORD_W-1:0]);
        end else begin
          speed_r <= (div_quo > Q_POS_MAX) ? 32'sh7FFF_FFFF
                                           : signed'(div_quo[mspid_pkg::WORD_W-1:0]);
        end
      end
      ST_ERR: begin
        ediff_r <= mspid_pkg::MUL_B_W'(target_r) - mspid_pkg::MUL_B_W'(meas);
        if (!loop_on) err_r <= '0;
      end
      ST_LIM: begin
        // drop errors beyond the limit or inside the deadband
        if (emag > mspid_pkg::MUL_B_W'(mspid_pkg::ERROR_LIMIT) ||
            emag < mspid_pkg::MUL_B_W'(dband_r)) begin
          err_r <= '0;
        end else begin
          err_r <= ediff_r[mspid_pkg::WORD_W-1:0];
        end
      end
      ST_M1:      acc_r <= mspid_pkg::ACC_W'(prod);
      ST_M2:      acc_r <= acc_r + mspid_pkg::ACC_W'(prod);
      ST_M3:      acc_r <= acc_r + mspid_pkg::ACC_W'(prod);
      ST_SCL:     scaled_r <= mspid_pkg::SCL_W'(acc_bias >>> mspid_pkg::GAIN_FRAC_BITS);
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result register: load in ST_OUT once the previous item has left
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_duty_r  <= duty_r;
      out_speed_r <= speed_r;
      out_pos_r   <= pos_r;
      out_err_r   <= err_r;
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.duty       = out_duty_r;
  assign out_ch.speed      = out_speed_r;
  assign out_ch.position   = out_pos_r;
  assign out_ch.error_used = out_err_r;

endmodule

/* design/mspid_chk.sv */
// ============================================================================
// mspid_chk: port-level checks for the motor speed/position PID
// Watches the item channels only; bound to the top level below.
// ============================================================================
module mspid_chk (
  input logic          clk,
  input logic          rst_n,
  mspid_in_if.sink     in_ch,
  mspid_out_if.source  out_ch
);

  // reset leaves no result pending
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after accept");

  // a result never appears too early after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |-> ##2 !$rose(out_ch.valid))
    else $error("result too early after accept");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.duty) &&
      $stable(out_ch.speed) && $stable(out_ch.position) && $stable(out_ch.error_used))
    else $error("stalled result changed");

endmodule

bind motor_speed_position_pid mspid_chk u_mspid_chk (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
